// File: hw/rtl/sdi_pkg.sv
// shared types, constants and the command frame table for the sd spi init sequencer
// no dependencies
package sdi_pkg;

    localparam int unsigned POLL_W   = 16;
    localparam int unsigned PRE_W    = 8;
    localparam int unsigned FRAME_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 16'd4095;
    localparam logic [PRE_W-1:0]  PREAMBLE_RESET   = 8'd10;

    localparam logic [7:0] DUMMY_BYTE  = 8'hFF;
    localparam logic [7:0] CMD0_BYTE   = 8'h40;
    localparam logic [7:0] CMD0_CRC    = 8'h95;
    localparam logic [7:0] CMD1_CRC    = 8'hFF;
    localparam logic [7:0] IDLE_RESP   = 8'h01;
    localparam logic [7:0] READY_RESP  = 8'h00;
    localparam logic [FRAME_W-1:0] FRAME_LAST = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE   = 1'd1;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_EXCHANGE = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_CMD,
        PH_POLL,
        PH_GAP,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [FRAME_W-1:0]  frame_index;
        logic [POLL_W-1:0]   poll_count;
        logic [PRE_W-1:0]    preamble_count;
        logic                in_op_cond_loop;
        logic                cs_level;
    } seq_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       done_res;
        logic       status;
    } seq_res_t;

    // byte of CMD0 (loop clear) or CMD1 (loop set) at a frame position
    function automatic logic [7:0] frame_byte(input logic cmd1, input logic [FRAME_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:       b = CMD0_BYTE | {7'd0, cmd1};
            FRAME_LAST: b = cmd1 ? CMD1_CRC : CMD0_CRC;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/sdi_step.sv
// next-state and result logic for one item of the sd spi init sequencer
// depends on sdi_pkg
module sdi_step (
    input  logic                       op,
    input  logic [7:0]                 rx_byte,
    input  logic [sdi_pkg::POLL_W-1:0] poll_limit,
    input  logic [sdi_pkg::PRE_W-1:0]  preamble_bytes,
    input  sdi_pkg::seq_state_t        cur,
    output sdi_pkg::seq_state_t        nxt,
    output sdi_pkg::seq_res_t          res
);

    logic [7:0] want;

    always_comb begin
        nxt  = cur;
        res  = '0;
        want = cur.in_op_cond_loop ? sdi_pkg::READY_RESP : sdi_pkg::IDLE_RESP;
        if (op == sdi_pkg::OP_START) begin
            nxt.frame_index     = '0;
            nxt.poll_count      = '0;
            nxt.in_op_cond_loop = 1'b0;
            res.valid           = 1'b1;
            if (preamble_bytes == '0) begin
                nxt.phase          = sdi_pkg::PH_CMD;
                nxt.preamble_count = '0;
                nxt.cs_level       = 1'b0;
                res.tx_byte        = sdi_pkg::frame_byte(1'b0, '0);
            end else begin
                nxt.phase          = sdi_pkg::PH_PRE;
                nxt.preamble_count = {{(sdi_pkg::PRE_W-1){1'b0}}, 1'b1};
                nxt.cs_level       = 1'b1;
                res.tx_byte        = sdi_pkg::DUMMY_BYTE;
            end
        end else begin
            unique case (cur.phase)
                sdi_pkg::PH_PRE: begin
                    res.valid = 1'b1;
                    if (cur.preamble_count < preamble_bytes) begin
                        nxt.preamble_count = cur.preamble_count + 1'b1;
                        nxt.cs_level       = 1'b1;
                        res.tx_byte        = sdi_pkg::DUMMY_BYTE;
                    end else begin
                        nxt.phase       = sdi_pkg::PH_CMD;
                        nxt.frame_index = '0;
                        nxt.cs_level    = 1'b0;
                        res.tx_byte     = sdi_pkg::frame_byte(cur.in_op_cond_loop, '0);
                    end
                end
                sdi_pkg::PH_CMD: begin
                    res.valid = 1'b1;
                    if (cur.frame_index < sdi_pkg::FRAME_LAST) begin
                        nxt.frame_index = cur.frame_index + 1'b1;
                        res.tx_byte     = sdi_pkg::frame_byte(cur.in_op_cond_loop,
                                                              cur.frame_index + 1'b1);
                    end else begin
                        nxt.phase      = sdi_pkg::PH_POLL;
                        nxt.poll_count = poll_limit;
                        res.tx_byte    = sdi_pkg::DUMMY_BYTE;
                    end
                end
                sdi_pkg::PH_POLL: begin
                    res.valid = 1'b1;
                    if (rx_byte != want && cur.poll_count != '0) begin
                        nxt.poll_count = cur.poll_count - 1'b1;
                        res.tx_byte    = sdi_pkg::DUMMY_BYTE;
                    end else if (cur.poll_count == '0 && !cur.in_op_cond_loop) begin
                        nxt.phase    = sdi_pkg::PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = sdi_pkg::STATUS_TIMEOUT;
                    end else begin
                        nxt.cs_level = 1'b1;
                        res.tx_byte  = sdi_pkg::DUMMY_BYTE;
                        if (cur.poll_count == '0) begin
                            nxt.phase = sdi_pkg::PH_GAP;
                        end else if (!cur.in_op_cond_loop) begin
                            nxt.in_op_cond_loop = 1'b1;
                            nxt.phase           = sdi_pkg::PH_GAP;
                        end else begin
                            nxt.phase = sdi_pkg::PH_FINAL;
                        end
                    end
                end
                sdi_pkg::PH_GAP: begin
                    res.valid       = 1'b1;
                    nxt.phase       = sdi_pkg::PH_CMD;
                    nxt.frame_index = '0;
                    nxt.cs_level    = 1'b0;
                    res.tx_byte     = sdi_pkg::frame_byte(cur.in_op_cond_loop, '0);
                end
                sdi_pkg::PH_FINAL: begin
                    res.valid    = 1'b1;
                    nxt.phase    = sdi_pkg::PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = sdi_pkg::STATUS_OK;
                end
                default: begin
                    res.valid = 1'b0;
                end
            endcase
            res.chip_select = nxt.cs_level;
        end
        if (op == sdi_pkg::OP_START) begin
            res.chip_select = nxt.cs_level;
        end
    end

endmodule

// File: hw/rtl/sd_spi_init_sequencer.sv
// top level of the sd card spi-mode bring-up sequencer: input register, state, result register
// depends on sdi_pkg and sdi_step
//
//   channel   prefix   direction   payload
//   input     s_       in          op, rx_byte
//   result    m_       out         tx_byte, chip_select, done_res, status
//   config    cfg_     in          cfg_index, cfg_data
//
// one item per cycle sustained while m_ready is high; an item's result appears after it has passed
// through the input register, then one pass of the step logic into the result register
// an exchange item while idle gives no result; every other item gives exactly one
// synchronous active-low reset; config registers come up at 4095 polls and 10 preamble bytes
// a stalled result register holds the input register, which then holds s_ready low
module sd_spi_init_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [7:0]                    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_tx_byte,
    output logic                          m_chip_select,
    output logic                          m_done_res,
    output logic                          m_status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                       in_valid_reg;
    logic                       op_reg;
    logic [7:0]                 rx_reg;
    logic [sdi_pkg::POLL_W-1:0] poll_limit_reg;
    logic [sdi_pkg::PRE_W-1:0]  preamble_reg;
    sdi_pkg::seq_state_t        state_reg;
    sdi_pkg::seq_state_t        state_next;
    sdi_pkg::seq_res_t          res_next;
    logic                       out_valid_reg;
    logic [7:0]                 tx_reg;
    logic                       cs_reg;
    logic                       done_reg;
    logic                       status_reg;
    logic                       advance;

    sdi_step u_step (
        .op             (op_reg),
        .rx_byte        (rx_reg),
        .poll_limit     (poll_limit_reg),
        .preamble_bytes (preamble_reg),
        .cur            (state_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            poll_limit_reg <= sdi_pkg::POLL_LIMIT_RESET;
            preamble_reg   <= sdi_pkg::PREAMBLE_RESET;
            state_reg      <= '{phase: sdi_pkg::PH_IDLE, frame_index: '0, poll_count: '0,
                                preamble_count: '0, in_op_cond_loop: 1'b0, cs_level: 1'b1};
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= res_next.valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sdi_pkg::REG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                    sdi_pkg::REG_PREAMBLE:   preamble_reg   <= cfg_data[sdi_pkg::PRE_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            rx_reg <= s_rx_byte;
        end
        if (advance && res_next.valid) begin
            tx_reg     <= res_next.tx_byte;
            cs_reg     <= res_next.chip_select;
            done_reg   <= res_next.done_res;
            status_reg <= res_next.status;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tx_byte     = tx_reg;
    assign m_chip_select = cs_reg;
    assign m_done_res    = done_reg;
    assign m_status      = status_reg;

`ifndef NO_ASSERTIONS
    a_done_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_tx_byte == 8'h00)
        else $error("done result carries a byte");

    a_status_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == sdi_pkg::STATUS_OK)
        else $error("status set on a result that is not done");

    a_timeout_cs_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res && m_status == sdi_pkg::STATUS_TIMEOUT |-> !m_chip_select)
        else $error("timeout left chip-select high");

    a_final_in_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == sdi_pkg::PH_FINAL |-> state_reg.in_op_cond_loop)
        else $error("final phase reached outside the op-cond loop");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(state_reg))
        else $error("state moved while the result was stalled");
`endif

endmodule

// File: tb/sd_spi_init_checker.sv
// watches the input, result and register channels of the sd spi init sequencer,
// predicts every reply and compares it with what the block sends
// depends on sdi_pkg
module sd_spi_init_checker
    import sdi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_op,
    input  logic [7:0]            s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [7:0]            m_tx_byte,
    input  logic                  m_chip_select,
    input  logic                  m_done_res,
    input  logic                  m_status,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    replies_checked,
    output int                    bringups_ok,
    output int                    bringups_timed_out
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] tx;
        logic       cs;
        logic       done;
        logic       status;
    } spi_reply_t;

    localparam logic [47:0] CMD0_FRAME = {CMD0_BYTE, 32'h0, CMD0_CRC};
    localparam logic [47:0] CMD1_FRAME = {8'h41, 32'h0, CMD1_CRC};

    logic [POLL_W-1:0]  poll_limit_reg;
    logic [PRE_W-1:0]   preamble_reg;

    phase_t             phase;
    logic [FRAME_W-1:0] frame_idx;
    logic [POLL_W-1:0]  polls_left;
    logic [PRE_W-1:0]   pre_sent;
    logic               op_cond;
    logic               cs;

    spi_reply_t reply_q[$];

    function automatic logic [7:0] frame_byte_at(input logic cmd1, input logic [FRAME_W-1:0] idx);
        logic [47:0] f;
        f = cmd1 ? CMD1_FRAME : CMD0_FRAME;
        return f[8 * (5 - idx) +: 8];
    endfunction

    task automatic push_reply(input logic [7:0] tx, input logic done, input logic st);
        spi_reply_t r;
        r.tx     = tx;
        r.cs     = cs;
        r.done   = done;
        r.status = st;
        reply_q.push_back(r);
    endtask

    task automatic begin_cmd_frame();
        phase     = PH_CMD;
        frame_idx = '0;
        cs        = 1'b0;
        push_reply(frame_byte_at(op_cond, frame_idx), 1'b0, STATUS_OK);
    endtask

    task automatic end_bringup(input logic st);
        phase = PH_IDLE;
        push_reply(8'h00, 1'b1, st);
    endtask

    task automatic step_bringup(input logic op, input logic [7:0] rx);
        logic [7:0] awaited;
        if (op == OP_START) begin
            frame_idx  = '0;
            polls_left = '0;
            pre_sent   = '0;
            op_cond    = 1'b0;
            cs         = 1'b1;
            if (preamble_reg == '0) begin
                begin_cmd_frame();
            end else begin
                phase    = PH_PRE;
                pre_sent = 8'd1;
                push_reply(DUMMY_BYTE, 1'b0, STATUS_OK);
            end
        end else begin
            case (phase)
                PH_PRE: begin
                    if (pre_sent < preamble_reg) begin
                        pre_sent = pre_sent + 8'd1;
                        cs       = 1'b1;
                        push_reply(DUMMY_BYTE, 1'b0, STATUS_OK);
                    end else begin
                        begin_cmd_frame();
                    end
                end
                PH_CMD: begin
                    if (frame_idx < FRAME_LAST) begin
                        frame_idx = frame_idx + 3'd1;
                        push_reply(frame_byte_at(op_cond, frame_idx), 1'b0, STATUS_OK);
                    end else begin
                        phase      = PH_POLL;
                        polls_left = poll_limit_reg;
                        push_reply(DUMMY_BYTE, 1'b0, STATUS_OK);
                    end
                end
                PH_POLL: begin
                    awaited = op_cond ? READY_RESP : IDLE_RESP;
                    if (rx != awaited && polls_left != '0) begin
                        polls_left = polls_left - 16'd1;
                        push_reply(DUMMY_BYTE, 1'b0, STATUS_OK);
                    end else if (polls_left == '0 && !op_cond) begin
                        end_bringup(STATUS_TIMEOUT);
                    end else begin
                        cs = 1'b1;
                        if (polls_left == '0) begin
                            phase = PH_GAP;
                        end else if (!op_cond) begin
                            op_cond = 1'b1;
                            phase   = PH_GAP;
                        end else begin
                            phase = PH_FINAL;
                        end
                        push_reply(DUMMY_BYTE, 1'b0, STATUS_OK);
                    end
                end
                PH_GAP:   begin_cmd_frame();
                PH_FINAL: end_bringup(STATUS_OK);
                default: ;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        spi_reply_t want_reply;
        spi_reply_t got_reply;
        if (!aresetn) begin
            poll_limit_reg     = POLL_LIMIT_RESET;
            preamble_reg       = PREAMBLE_RESET;
            phase              = PH_IDLE;
            frame_idx          = '0;
            polls_left         = '0;
            pre_sent           = '0;
            op_cond            = 1'b0;
            cs                 = 1'b1;
            reply_q.delete();
            fail_count         = 0;
            replies_checked    = 0;
            bringups_ok        = 0;
            bringups_timed_out = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_POLL_LIMIT: poll_limit_reg = cfg_data;
                    REG_PREAMBLE:   preamble_reg   = cfg_data[PRE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                step_bringup(s_op, s_rx_byte);
            if (m_valid && m_ready) begin
                got_reply = {m_tx_byte, m_chip_select, m_done_res, m_status};
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected item: tx %h cs %b done %b status %b",
                             $time, m_tx_byte, m_chip_select, m_done_res, m_status);
                    fail_count++;
                end else begin
                    want_reply = reply_q.pop_front();
                    replies_checked++;
                    if (got_reply !== want_reply) begin
                        $display("%0t: mismatch: expected tx %h cs %b done %b status %b, got tx %h cs %b done %b status %b",
                                 $time, want_reply.tx, want_reply.cs, want_reply.done,
                                 want_reply.status, m_tx_byte, m_chip_select, m_done_res,
                                 m_status);
                        fail_count++;
                    end
                end
                if (m_done_res === 1'b1) begin
                    if (m_status === STATUS_OK)
                        bringups_ok++;
                    else
                        bringups_timed_out++;
                end
            end
        end
        pending = reply_q.size();
    end

endmodule

// File: tb/sd_spi_init_sequencer_tb.sv
// testbench top for the sd spi init sequencer: clock, reset, register writes and
// bring-up stimulus with random idling; checking is done by sd_spi_init_checker
// depends on sdi_pkg, sd_spi_init_sequencer and sd_spi_init_checker
module sd_spi_init_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdi_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_op      = OP_START;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_ready   = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_POLL_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_tx_byte;
    logic       m_chip_select;
    logic       m_done_res;
    logic       m_status;
    logic       cfg_ready;

    int         fail_count;
    int         pending;
    int         replies_checked;
    int         bringups_ok;
    int         bringups_timed_out;
    int         items_sent   = 0;
    int         stall_left   = 0;
    bit         idling_on    = 1'b1;
    logic [7:0] cur_preamble = PREAMBLE_RESET;

    always #5 aclk = ~aclk;

    sd_spi_init_sequencer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_chip_select (m_chip_select),
        .m_done_res    (m_done_res),
        .m_status      (m_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sd_spi_init_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_tx_byte          (m_tx_byte),
        .m_chip_select      (m_chip_select),
        .m_done_res         (m_done_res),
        .m_status           (m_status),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending            (pending),
        .replies_checked    (replies_checked),
        .bringups_ok        (bringups_ok),
        .bringups_timed_out (bringups_timed_out)
    );

    always @(posedge aclk) begin
        if (!idling_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] rx);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_PREAMBLE)
            cur_preamble = data[7:0];
    endtask

    // wait for every reply, then let any reply-less item clear the pipeline
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] card_reply();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return IDLE_RESP;
        else if (pick < 7)
            return READY_RESP;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_bringups(input logic [15:0] poll, input logic [7:0] pre, input int budget);
        int sent;
        int len;
        int k;
        write_reg(REG_POLL_LIMIT, poll);
        write_reg(REG_PREAMBLE, {8'($urandom_range(0, 255)), pre});
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
                sent++;
            end
            send_item(OP_START, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(0, 12);
            else
                len = $urandom_range(cur_preamble + 16, cur_preamble + 50);
            for (k = 0; k < len; k++)
                send_item(OP_EXCHANGE, card_reply());
            sent += len + 1;
        end
        drain();
    endtask

    initial begin
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // exchange with nothing running
        send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
        drain();
        write_reg(REG_POLL_LIMIT, 16'd1);
        write_reg(REG_PREAMBLE, {8'($urandom_range(0, 255)), 8'd0});

        // no preamble, idle response only after the limit: timeout, cs left low
        send_item(OP_START, 8'($urandom_range(0, 255)));
        for (k = 0; k < 6; k++)
            send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
        send_item(OP_EXCHANGE, 8'hFF);
        send_item(OP_EXCHANGE, IDLE_RESP);
        send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));

        // straight path to success
        send_item(OP_START, 8'($urandom_range(0, 255)));
        for (k = 0; k < 6; k++)
            send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
        send_item(OP_EXCHANGE, IDLE_RESP);
        for (k = 0; k < 7; k++)
            send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
        send_item(OP_EXCHANGE, READY_RESP);
        send_item(OP_EXCHANGE, 8'($urandom_range(0, 255)));
        drain();

        run_bringups(POLL_LIMIT_RESET, PREAMBLE_RESET, 150);
        run_bringups(16'd0, 8'd0, 180);
        run_bringups(16'hFFFF, 8'hFF, 250);
        run_bringups(16'd1, 8'd1, 180);
        run_bringups(16'd2, 8'd3, 180);
        idling_on = 1'b0;
        run_bringups(16'($urandom_range(0, 6)), 8'($urandom_range(0, 12)), 150);

        $display("summary: %0d items sent, %0d replies checked over seven register settings",
                 items_sent, replies_checked);
        $display("summary: %0d bring-ups succeeded, %0d ended in idle-response timeout",
                 bringups_ok, bringups_timed_out);
        if (fail_count == 0) begin
            $display("sd_spi_init_sequencer_tb: PASS");
        end else begin
            $display("sd_spi_init_sequencer_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d replies outstanding", pending);
        $display("sd_spi_init_sequencer_tb: FAIL");
        $finish;
    end

endmodule

// File: sd_spi_init_sequencer.f
hw/rtl/sdi_pkg.sv
hw/rtl/sdi_step.sv
hw/rtl/sd_spi_init_sequencer.sv
tb/sd_spi_init_checker.sv
tb/sd_spi_init_sequencer_tb.sv
